// File: src/ris_pkg.sv
// Shared types and constants for the rotated immediate splitter.
package ris_pkg;

  localparam int unsigned NumChunks = 4;
  localparam int unsigned NumScan   = 4;

  localparam logic [31:0] TopNibble = 32'hF000_0000;
  localparam logic [31:0] LowNibble = 32'h0000_000F;
  localparam logic [5:0]  FullEnd   = 6'd32;
  localparam logic [5:0]  WrapEnd   = 6'd28;
  localparam logic [5:0]  WrapPos   = 6'd4;
  localparam logic [4:0]  WrapRot   = 5'd4;
  localparam logic [5:0]  ChunkBits = 6'd8;

  // One constant on its way through the scan stages.
  typedef struct packed {
    logic [31:0]          value;
    logic [5:0]           pos;
    logic [5:0]           scan_end;
    logic [2:0]           count;
    logic                 done;
    logic [3:0][7:0]      chunks;
    logic [3:0][4:0]      rots;
  } ris_item_t;

endpackage

// File: src/rotated_immediate_splitter_core.sv
// Top level of the rotated immediate splitter.
//
// Splits a 32-bit constant into one to four 8-bit chunks with even right
// rotate amounts; ORing the rotated chunks rebuilds the constant.
// Input: a transaction is taken at a rising edge with start high and
// busy low; value_i carries the constant.
// Output: each chunk is on chunk_o/rotate_right_o for one cycle, marked by
// result_valid_o; last_o flags the final chunk of a constant. Chunks of one
// constant follow each other in consecutive cycles.
// Pipeline: an entry register, four scan stages (one chunk search each) and
// the output register, through which each constant passes in that order.
// Throughput: the output port carries one chunk a cycle and takes the next
// constant only as the last chunk of the current one leaves; the pipeline holds
// up to six constants and busy rises when it backs up behind the output.
// Reset: clears all valid bits; nothing is in flight afterwards.
// The receiver cannot stall: results are never held back.
module rotated_immediate_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic [7:0]  chunk_o,
  output logic [4:0]  rotate_right_o,
  output logic        last_o
);
  import ris_pkg::*;

  logic      stg_valid [NumScan + 1];
  ris_item_t stg_item  [NumScan + 1];
  logic      stg_ready [NumScan + 2];

  logic      entry_valid_q;
  ris_item_t entry_item_q;
  ris_item_t entry_item_d;
  logic      wrap;

  // Decode the zero and wrap cases before the scan.
  assign wrap = (|(value_i & TopNibble)) && (|(value_i & LowNibble));

  always_comb begin
    entry_item_d          = '0;
    entry_item_d.value    = value_i;
    entry_item_d.pos      = 6'd0;
    entry_item_d.scan_end = FullEnd;
    if (value_i == 32'h0000_0000) begin
      entry_item_d.count = 3'd1;
      entry_item_d.done  = 1'b1;
    end else if (wrap) begin
      entry_item_d.chunks[0] = {value_i[3:0], value_i[31:28]};
      entry_item_d.rots[0]   = WrapRot;
      entry_item_d.count     = 3'd1;
      entry_item_d.pos       = WrapPos;
      entry_item_d.scan_end  = WrapEnd;
    end
  end

  assign stg_ready[0] = !entry_valid_q || stg_ready[1];
  assign busy         = !stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (stg_ready[0]) begin
      entry_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[0]) begin
      entry_item_q <= entry_item_d;
    end
  end

  assign stg_valid[0] = entry_valid_q;
  assign stg_item[0]  = entry_item_q;

  for (genvar k = 1; k <= NumScan; k++) begin : g_scan
    ris_scan_stage u_scan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k-1]),
      .item_i  (stg_item[k-1]),
      .ready_o (stg_ready[k]),
      .valid_o (stg_valid[k]),
      .item_o  (stg_item[k]),
      .ready_i (stg_ready[k+1])
    );
  end

  ris_serializer u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (stg_valid[NumScan]),
    .item_i         (stg_item[NumScan]),
    .ready_o        (stg_ready[NumScan + 1]),
    .result_valid_o (result_valid_o),
    .chunk_o        (chunk_o),
    .rotate_right_o (rotate_right_o),
    .last_o         (last_o)
  );

  // Chunks of one constant leave without gaps.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside a chunk sequence");

  // Rotate amounts are always even.
  a_even_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !rotate_right_o[0])
    else $error("odd rotate amount");

  // A zero chunk only stands alone, for the zero constant.
  a_zero_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (chunk_o == 8'h00) |-> last_o && (rotate_right_o == 5'd0))
    else $error("zero chunk outside the zero constant case");

endmodule

// File: src/ris_scan_stage.sv
// One scan step: find the next non-zero bit pair and take the byte there.
module ris_scan_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ris_pkg::ris_item_t item_i,
  output logic              ready_o,
  output logic              valid_o,
  output ris_pkg::ris_item_t item_o,
  input  logic              ready_i
);
  import ris_pkg::*;

  logic      valid_q;
  ris_item_t item_q;
  ris_item_t item_d;
  logic [15:0] hit;
  logic        hit_any;
  logic [4:0]  hit_pos;
  logic [39:0] shifted;
  logic [1:0]  slot;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      hit[i] = (|item_i.value[2*i +: 2]) && (6'(2 * i) >= item_i.pos)
               && (6'(2 * i) < item_i.scan_end);
    end
  end

  always_comb begin
    hit_pos = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (hit[i]) hit_pos = 5'(2 * i);
    end
  end

  assign hit_any = |hit;
  assign shifted = {8'h00, item_i.value} >> hit_pos;
  assign slot    = item_i.count[1:0];

  always_comb begin
    item_d = item_i;
    if (!item_i.done) begin
      if (!hit_any) begin
        item_d.done = 1'b1;
      end else begin
        item_d.chunks[slot] = shifted[7:0];
        item_d.rots[slot]   = 5'd0 - hit_pos;
        item_d.count        = item_i.count + 3'd1;
        item_d.pos          = {1'b0, hit_pos} + ChunkBits;
        // Stop on a chunk near the scan end or once all four are taken.
        if (({1'b0, hit_pos} >= (item_i.scan_end - ChunkBits)) ||
            (item_i.count == 3'(NumChunks - 1))) begin
          item_d.done = 1'b1;
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/ris_serializer.sv
// Output stage: strobe the chunks of one constant out, one per cycle.
module ris_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ris_pkg::ris_item_t item_i,
  output logic              ready_o,
  output logic              result_valid_o,
  output logic [7:0]        chunk_o,
  output logic [4:0]        rotate_right_o,
  output logic              last_o
);
  import ris_pkg::*;

  logic      valid_q;
  ris_item_t item_q;
  logic [1:0] idx_q;
  logic [1:0] last_idx;
  logic       is_last;

  assign last_idx = 2'(item_q.count - 3'd1);
  assign is_last  = (idx_q == last_idx);
  // Take the next transaction in the cycle the last chunk leaves.
  assign ready_o  = !valid_q || is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      idx_q   <= 2'd0;
    end else begin
      idx_q   <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_i;
    end
  end

  assign result_valid_o = valid_q;
  assign chunk_o        = item_q.chunks[idx_q];
  assign rotate_right_o = item_q.rots[idx_q];
  assign last_o         = valid_q && is_last;

endmodule
